// File: design/heap_sort_engine_macros.svh
// Assertion macros shared by the heap sort engine RTL.
`ifndef HEAP_SORT_ENGINE_MACROS_SVH
`define HEAP_SORT_ENGINE_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is high.
`define HSE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");
// Next-cycle implication, disabled while reset is high.
`define HSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");
`else
`define HSE_ASSERT_IMPL(label, clk, rst, ante, cons)
`define HSE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: design/hse_pkg.sv
// Types and constants of the heap sort engine.
package hse_pkg;

   localparam int DEPTH   = 64;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int CHILD_W = IDX_W + 1;
   localparam int DATA_W  = 32;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last;
   } req_payload_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] sorted_value;
      logic                     last_out;
      logic                     overflow;
   } rsp_payload_type;

   typedef struct packed {
      logic              we;
      logic [IDX_W-1:0]  waddr;
      logic [DATA_W-1:0] wdata;
      logic              re;
      logic [IDX_W-1:0]  raddr;
   } mem_cmd_type;

endpackage

// File: design/heap_sort_engine.sv
// Heap sort engine top level: element memory, sequencer and output register.
//
//   channel | direction | word                        | handshake
//   req     | in        | value, last                 | req_valid / req_ready
//   rsp     | out       | sorted_value, last_out, ovf | rsp_valid / rsp_ready
//
// Loading takes one word per cycle; req_ready stays low from the last word
// until the final result has been loaded into the output register.
// Sorting is bound by the single memory read port.
// Readout loads each result from memory into the output register.
// Reset is synchronous and clears only the sequencer state, the fill count,
// the overflow-seen flag and rsp_valid; the memory is not cleared. rsp_ready low holds the result and stalls readout.
`include "heap_sort_engine_macros.svh"
module heap_sort_engine (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  hse_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output hse_pkg::rsp_payload_type rsp_data
);
   import hse_pkg::*;

   mem_cmd_type     mem_cmd;
   logic [31:0]     rd_data;
   logic            out_free;
   logic            out_load;
   rsp_payload_type out_word;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff;

   hse_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_cmd.we),
      .wr_addr (mem_cmd.waddr),
      .wr_data (mem_cmd.wdata),
      .rd_en   (mem_cmd.re),
      .rd_addr (mem_cmd.raddr),
      .rd_data (rd_data)
   );

   hse_sorter u_sorter (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rd_data   (rd_data),
      .out_free  (out_free),
      .mem_cmd   (mem_cmd),
      .out_load  (out_load),
      .out_word  (out_word)
   );

   // output register: free when empty or being taken this cycle
   assign out_free = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (out_load) begin
         rsp_data_ff <= out_word;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `HSE_ASSERT_IMPL(a_no_overwrite, clock, reset, out_load, !rsp_valid_ff)

endmodule

// File: design/hse_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/hse_sorter.sv
// Load, heapsort and readout sequencer working on the element memory.
`include "heap_sort_engine_macros.svh"
module hse_sorter (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  hse_pkg::req_payload_type req_data,
   input  logic [31:0]              rd_data,
   input  logic                     out_free,
   output hse_pkg::mem_cmd_type     mem_cmd,
   output logic                     out_load,
   output hse_pkg::rsp_payload_type out_word
);
   import hse_pkg::*;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SD_TOP,
      ST_SD_HELD,
      ST_SD_CHILD,
      ST_SD_C1,
      ST_SD_C2,
      ST_SD_CMP,
      ST_SD_NEXT,
      ST_SW_RD0,
      ST_SW_RDK,
      ST_SW_WR,
      ST_EMIT_RD,
      ST_EMIT_LD
   } state_type;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         fill_count_ff, fill_count_in;
   logic                     ovf_seen_ff, ovf_seen_in;
   logic                     set_ovf_ff, set_ovf_in;
   logic [IDX_W-1:0]         last_idx_ff, last_idx_in;
   logic [IDX_W-1:0]         k_ff, k_in;
   logic [IDX_W-1:0]         top_ff, top_in;
   logic [IDX_W-1:0]         end_ff, end_in;
   logic signed [DATA_W-1:0] held_ff, held_in;
   logic signed [DATA_W-1:0] cval_ff, cval_in;
   logic [IDX_W-1:0]         cidx_ff, cidx_in;
   logic                     build_ff, build_in;
   logic [IDX_W-1:0]         out_idx_ff, out_idx_in;

   logic                     room;
   logic [CNT_W-1:0]         count_w;
   logic [CNT_W-1:0]         count_m1;
   logic [IDX_W-1:0]         new_last;
   logic [CHILD_W-1:0]       child_w;
   logic signed [DATA_W-1:0] rd_signed;

   // store address arithmetic
   assign room      = (fill_count_ff < CNT_W'(DEPTH));
   assign count_w   = fill_count_ff + CNT_W'(room);
   assign count_m1  = count_w - CNT_W'(1);
   assign new_last  = count_m1[IDX_W-1:0];
   assign child_w   = {top_ff, 1'b1};
   assign rd_signed = $signed(rd_data);

   // next-state and memory command
   always_comb begin
      state_in      = state_ff;
      fill_count_in = fill_count_ff;
      ovf_seen_in   = ovf_seen_ff;
      set_ovf_in    = set_ovf_ff;
      last_idx_in   = last_idx_ff;
      k_in          = k_ff;
      top_in        = top_ff;
      end_in        = end_ff;
      held_in       = held_ff;
      cval_in       = cval_ff;
      cidx_in       = cidx_ff;
      build_in      = build_ff;
      out_idx_in    = out_idx_ff;
      mem_cmd       = '0;
      req_ready     = 1'b0;
      out_load      = 1'b0;
      out_word.sorted_value = rd_signed;
      out_word.last_out     = (out_idx_ff == last_idx_ff);
      out_word.overflow     = set_ovf_ff;

      case (state_ff)
         // take one word a cycle, drop it when the store is full
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (room) begin
                  mem_cmd.we    = 1'b1;
                  mem_cmd.waddr = fill_count_ff[IDX_W-1:0];
                  mem_cmd.wdata = req_data.value;
                  fill_count_in = count_w;
               end else begin
                  ovf_seen_in = 1'b1;
               end
               if (req_data.last) begin
                  set_ovf_in    = ovf_seen_ff | ~room;
                  last_idx_in   = new_last;
                  k_in          = new_last >> 1;
                  build_in      = 1'b1;
                  fill_count_in = '0;
                  ovf_seen_in   = 1'b0;
                  state_in      = ST_SD_TOP;
               end
            end
         end
         // start a heap-build sift at node k
         ST_SD_TOP: begin
            mem_cmd.re    = 1'b1;
            mem_cmd.raddr = k_ff;
            top_in        = k_ff;
            end_in        = last_idx_ff;
            state_in      = ST_SD_HELD;
         end
         ST_SD_HELD: begin
            held_in  = rd_signed;
            state_in = ST_SD_CHILD;
         end
         // leaf reached: settle the held value, else fetch the left child
         ST_SD_CHILD: begin
            if (child_w > {1'b0, end_ff}) begin
               mem_cmd.we    = 1'b1;
               mem_cmd.waddr = top_ff;
               mem_cmd.wdata = held_ff;
               state_in      = ST_SD_NEXT;
            end else begin
               mem_cmd.re    = 1'b1;
               mem_cmd.raddr = child_w[IDX_W-1:0];
               cidx_in       = child_w[IDX_W-1:0];
               state_in      = ST_SD_C1;
            end
         end
         // hold the left child, fetch the right one if it exists
         ST_SD_C1: begin
            cval_in = rd_signed;
            if (cidx_ff < end_ff) begin
               mem_cmd.re    = 1'b1;
               mem_cmd.raddr = cidx_ff + IDX_W'(1);
               state_in      = ST_SD_C2;
            end else begin
               state_in = ST_SD_CMP;
            end
         end
         // keep the larger child
         ST_SD_C2: begin
            if (cval_ff < rd_signed) begin
               cval_in = rd_signed;
               cidx_in = cidx_ff + IDX_W'(1);
            end
            state_in = ST_SD_CMP;
         end
         // move the child up and descend, or settle the held value
         ST_SD_CMP: begin
            mem_cmd.we    = 1'b1;
            mem_cmd.waddr = top_ff;
            if (held_ff < cval_ff) begin
               mem_cmd.wdata = cval_ff;
               top_in        = cidx_ff;
               state_in      = ST_SD_CHILD;
            end else begin
               mem_cmd.wdata = held_ff;
               state_in      = ST_SD_NEXT;
            end
         end
         // advance through build, then extraction, then readout
         ST_SD_NEXT: begin
            if (build_ff) begin
               if (k_ff == '0) begin
                  build_in = 1'b0;
                  if (last_idx_ff == '0) begin
                     out_idx_in = '0;
                     state_in   = ST_EMIT_RD;
                  end else begin
                     k_in     = last_idx_ff;
                     state_in = ST_SW_RD0;
                  end
               end else begin
                  k_in     = k_ff - IDX_W'(1);
                  state_in = ST_SD_TOP;
               end
            end else begin
               if (k_ff == IDX_W'(1)) begin
                  out_idx_in = '0;
                  state_in   = ST_EMIT_RD;
               end else begin
                  k_in     = k_ff - IDX_W'(1);
                  state_in = ST_SW_RD0;
               end
            end
         end
         // swap root and slot k, then sift the new root over 0..k-1
         ST_SW_RD0: begin
            mem_cmd.re    = 1'b1;
            mem_cmd.raddr = '0;
            state_in      = ST_SW_RDK;
         end
         ST_SW_RDK: begin
            cval_in       = rd_signed;
            mem_cmd.re    = 1'b1;
            mem_cmd.raddr = k_ff;
            state_in      = ST_SW_WR;
         end
         ST_SW_WR: begin
            held_in       = rd_signed;
            mem_cmd.we    = 1'b1;
            mem_cmd.waddr = k_ff;
            mem_cmd.wdata = cval_ff;
            top_in        = '0;
            end_in        = k_ff - IDX_W'(1);
            state_in      = ST_SD_CHILD;
         end
         // read the next word once the output register frees up
         ST_EMIT_RD: begin
            if (out_free) begin
               mem_cmd.re    = 1'b1;
               mem_cmd.raddr = out_idx_ff;
               state_in      = ST_EMIT_LD;
            end
         end
         ST_EMIT_LD: begin
            out_load = 1'b1;
            if (out_idx_ff == last_idx_ff) begin
               state_in = ST_LOAD;
            end else begin
               out_idx_in = out_idx_ff + IDX_W'(1);
               state_in   = ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // state and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         fill_count_ff <= '0;
         ovf_seen_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_count_ff <= fill_count_in;
         ovf_seen_ff   <= ovf_seen_in;
      end
      set_ovf_ff  <= set_ovf_in;
      last_idx_ff <= last_idx_in;
      k_ff        <= k_in;
      top_ff      <= top_in;
      end_ff      <= end_in;
      held_ff     <= held_in;
      cval_ff     <= cval_in;
      cidx_ff     <= cidx_in;
      build_ff    <= build_in;
      out_idx_ff  <= out_idx_in;
   end

   `HSE_ASSERT_IMPL(a_no_rw_clash, clock, reset, mem_cmd.we && mem_cmd.re, mem_cmd.waddr != mem_cmd.raddr)
   `HSE_ASSERT_IMPL(a_sort_wr_in_set, clock, reset, mem_cmd.we && state_ff != ST_LOAD, mem_cmd.waddr <= last_idx_ff)
   `HSE_ASSERT_NEXT(a_close_set, clock, reset, req_valid && req_ready && req_data.last, state_ff == ST_SD_TOP && fill_count_ff == '0 && !ovf_seen_ff)

endmodule

// File: dv/tb_heap_sort_engine.sv
// Testbench for the heap sort engine: sends sets of signed words and checks the sorted output.
module tb_heap_sort_engine;
   timeunit 1ns;
   timeprecision 1ps;

   import hse_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int TAIL_CYCLES  = 32;
   localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_data;

   // sender idle and receiver stall odds, in percent
   int idle_pct  = 0;
   int stall_pct = 0;

   int mismatch_count = 0;
   int cycle_count    = 0;

   // predicted contents of the engine's store for the open set
   logic signed [DATA_W-1:0] held_values [DEPTH];
   int                       held_count   = 0;
   logic                     dropped_seen = 1'b0;

   // sorted words still owed by the engine, oldest first
   rsp_payload_type sorted_words_due [$];
   rsp_payload_type due_word;

   heap_sort_engine i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_heap_sort_engine NOT OK");
         $finish;
      end
   end

   // stall the result channel at random
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   // store one accepted word; on the closing word, sort the set and queue the results
   task automatic absorb_word(input req_payload_type w);
      logic signed [DATA_W-1:0] key;
      rsp_payload_type          r;
      int                       i;
      int                       j;
      if (held_count < DEPTH) begin
         held_values[held_count] = w.value;
         held_count++;
      end else begin
         dropped_seen = 1'b1;
      end
      if (w.last) begin
         // ascending insertion sort; order among equal values is not visible
         for (i = 1; i < held_count; i++) begin
            key = held_values[i];
            j   = i - 1;
            while (j >= 0 && held_values[j] > key) begin
               held_values[j+1] = held_values[j];
               j--;
            end
            held_values[j+1] = key;
         end
         for (i = 0; i < held_count; i++) begin
            r.sorted_value = held_values[i];
            r.last_out     = (i == held_count - 1);
            r.overflow     = dropped_seen;
            sorted_words_due.push_back(r);
         end
         held_count   = 0;
         dropped_seen = 1'b0;
      end
   endtask

   // check every accepted result word against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (sorted_words_due.size() == 0) begin
            report_mismatch($sformatf("unexpected word value %0d", rsp_data.sorted_value));
         end else begin
            due_word = sorted_words_due.pop_front();
            if (rsp_data.sorted_value !== due_word.sorted_value)
               report_mismatch($sformatf("sorted_value %0d, expected %0d",
                                         rsp_data.sorted_value, due_word.sorted_value));
            if (rsp_data.last_out !== due_word.last_out)
               report_mismatch($sformatf("last_out %b, expected %b",
                                         rsp_data.last_out, due_word.last_out));
            if (rsp_data.overflow !== due_word.overflow)
               report_mismatch($sformatf("overflow %b, expected %b",
                                         rsp_data.overflow, due_word.overflow));
         end
      end
   end

   // send one word; called right after a rising edge
   task automatic send_word(input logic signed [DATA_W-1:0] value, input logic last);
      req_payload_type w;
      w.value = value;
      w.last  = last;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      absorb_word(w);
   endtask

   // drop valid and hold until every owed result has arrived
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (sorted_words_due.size() != 0) @(posedge clock);
   endtask

   task automatic send_set(input logic signed [DATA_W-1:0] values [$]);
      foreach (values[i]) send_word(values[i], i == values.size() - 1);
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(9))
         0, 1, 2, 3: pick_value = $urandom;
         4, 5, 6:    pick_value = $signed($urandom_range(8)) - 4;
         7: begin
            case ($urandom_range(4))
               0:       pick_value = VAL_MIN;
               1:       pick_value = VAL_MAX;
               2:       pick_value = 0;
               3:       pick_value = -1;
               default: pick_value = 1;
            endcase
         end
         default: pick_value = $signed($urandom_range(2000)) - 1000;
      endcase
   endfunction

   // small sets of extremes, duplicates and presorted runs, drained one by one
   task automatic test_directed();
      idle_pct  = 0;
      stall_pct = 0;
      send_set('{5});
      wait_for_results();
      send_set('{VAL_MAX});
      wait_for_results();
      send_set('{VAL_MIN});
      wait_for_results();
      send_set('{VAL_MAX, VAL_MIN, 0, -1, 1, VAL_MIN, VAL_MAX});
      wait_for_results();
      send_set('{1, 2, 3, 4});
      wait_for_results();
      send_set('{4, 3, 2, 1});
      wait_for_results();
      send_set('{7, 7, 7});
      wait_for_results();
   endtask

   // fill the store exactly, then overrun it so the closing word is dropped
   task automatic test_full_store();
      int i;
      idle_pct  = 34;
      stall_pct = 34;
      for (i = 0; i < DEPTH; i++) send_word(pick_value(), i == DEPTH - 1);
      for (i = 0; i < DEPTH + 2; i++) send_word(pick_value(), i == DEPTH + 1);
      // overflow flag must clear for the next set
      send_word(pick_value(), 1'b0);
      send_word(pick_value(), 1'b1);
   endtask

   // random sets, mostly small, now and then a large one
   task automatic test_random_sets(input int sender_idle, input int receiver_stall,
                                   input int word_budget);
      int sent;
      int set_size;
      int i;
      idle_pct  = sender_idle;
      stall_pct = receiver_stall;
      sent      = 0;
      while (sent < word_budget) begin
         if ($urandom_range(19) == 0) set_size = $urandom_range(32, DEPTH);
         else set_size = $urandom_range(1, 12);
         for (i = 0; i < set_size; i++) send_word(pick_value(), i == set_size - 1);
         sent += set_size;
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_store();
      test_random_sets(0, 0, 12);
      test_random_sets(54, 0, 12);
      test_random_sets(0, 54, 12);
      test_random_sets(34, 34, 12);
      // drain, then watch for stray words
      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_heap_sort_engine OK");
      end else begin
         $display("tb_heap_sort_engine NOT OK");
      end
      $finish;
   end

endmodule
